// ===== sv/tofrk_pkg.sv =====
// ============================================================================
// tofrk_pkg
// Shared constants and types for the time-of-flight kinematics pipeline.
// ============================================================================
package tofrk_pkg;

   localparam int unsigned MassWidth = 24;
   localparam logic [MassWidth-1:0] MassReset = 24'd962115;

   // c^2 and c in Q16 cm/ns units.
   localparam logic [25:0] C2q = 26'd58900819;
   localparam logic [20:0] Cq  = 21'd1964720;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusZeroTime = 2'd1;
   localparam logic [1:0] StatusFast     = 2'd2;

   localparam logic [39:0] ECap = 40'hFF_FFFF_FFFF;

   // Quotient and square-root steps are one bit per pipeline stage.
   localparam int unsigned RatioBits = 64;
   localparam int unsigned RootBits  = 32;
   localparam int unsigned GammaBits = 65;
   localparam int unsigned AxisBits  = 24;

   // Per-item side data that rides along every stage.
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  neg;
      logic [16:0] mag_x;
      logic [16:0] mag_y;
      logic [16:0] mag_z;
      logic [15:0] t;
   } side_type;

endpackage

// ===== sv/tofrk_front.sv =====
// ============================================================================
// tofrk_front
// Magnitudes, squared radius, N and D, and the special-case status.
// Two register stages.
// ============================================================================
module tofrk_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [16:0]       pos_x,
   input  logic signed [16:0]       pos_y,
   input  logic signed [16:0]       pos_z,
   input  logic [15:0]              flight_time,
   output logic                     out_valid,
   output tofrk_pkg::side_type      out_side,
   output logic [63:0]              out_num,
   output logic [63:0]              out_den
);
   import tofrk_pkg::*;

   logic        v1_ff;
   side_type    s1_ff, s1_in;
   logic [35:0] r2_ff;
   logic [31:0] tt_ff;
   logic        v2_ff;
   side_type    s2_ff, s2_in;
   logic [63:0] n_ff, d_ff;
   logic [63:0] n_w, d_w;
   logic [34:0] sx, sy, sz;

   function automatic logic [16:0] mag17(input logic signed [16:0] p);
      logic [17:0] m;
      m = p[16] ? (18'h20000 - {1'b0, p}) : {1'b0, p};
      return m[16:0];
   endfunction

   always_comb begin
      s1_in = '0;
      s1_in.neg   = {pos_z[16], pos_y[16], pos_x[16]};
      s1_in.mag_x = mag17(pos_x);
      s1_in.mag_y = mag17(pos_y);
      s1_in.mag_z = mag17(pos_z);
      s1_in.t     = flight_time;
      s1_in.status = StatusOk;
   end

   // A magnitude of 2^16 is held as 17 bits, so squares fit in 34 bits.
   assign sx = {18'd0, s1_in.mag_x} * {18'd0, s1_in.mag_x};
   assign sy = {18'd0, s1_in.mag_y} * {18'd0, s1_in.mag_y};
   assign sz = {18'd0, s1_in.mag_z} * {18'd0, s1_in.mag_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         r2_ff <= 36'(sx) + 36'(sy) + 36'(sz);
         tt_ff <= 32'(flight_time) * 32'(flight_time);
      end
   end

   assign n_w = {8'd0, r2_ff, 20'd0};
   assign d_w = 64'(tt_ff) * 64'(C2q);

   always_comb begin
      s2_in = s1_ff;
      if (s1_ff.t == 16'd0) begin
         s2_in.status = StatusZeroTime;
      end else if (n_w >= d_w) begin
         s2_in.status = StatusFast;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
         n_ff  <= n_w;
         d_ff  <= d_w;
      end
   end

   assign out_valid = v2_ff;
   assign out_side  = s2_ff;
   assign out_num   = n_ff;
   assign out_den   = d_ff;
endmodule

// ===== sv/tofrk_gamma.sv =====
// ============================================================================
// tofrk_gamma
// Pipelined gamma: s2 = (D-N)/D in Q64 by restoring division, bit-serial
// square root, then 2^64 / s rounded as the model does. One bit per stage.
// ============================================================================
module tofrk_gamma (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  tofrk_pkg::side_type      in_side,
   input  logic [63:0]              in_num,
   input  logic [63:0]              in_den,
   output logic                     out_valid,
   output tofrk_pkg::side_type      out_side,
   output logic [63:0]              out_gamma
);
   import tofrk_pkg::*;

   localparam int unsigned DivStages = RatioBits;
   localparam int unsigned SqStages  = RootBits;
   localparam int unsigned GStages   = GammaBits;

   // Division stage arrays.
   logic     dv_ff  [DivStages+1];
   side_type ds_ff  [DivStages+1];
   logic     dz_ff  [DivStages+1];
   logic [64:0] drem_ff [DivStages+1];
   logic [63:0] dden_ff [DivStages+1];
   logic [63:0] dq_ff   [DivStages+1];

   // Square-root stage arrays: remainder and root per step.
   logic     qv_ff  [SqStages+1];
   side_type qs_ff  [SqStages+1];
   logic     qz_ff  [SqStages+1];
   logic [63:0] qrad_ff [SqStages+1];
   logic [33:0] qrem_ff [SqStages+1];
   logic [31:0] qroot_ff [SqStages+1];

   // Reciprocal stage arrays: 2^64 over s, one quotient bit a stage.
   logic     gv_ff  [GStages+1];
   side_type gs_ff  [GStages+1];
   logic     gz_ff  [GStages+1];
   logic [32:0] grem_ff [GStages+1];
   logic [31:0] gden_ff [GStages+1];
   logic [64:0] gq_ff   [GStages+1];

   logic        fv_ff;
   side_type    fs_ff;
   logic [63:0] fg_ff;

   always_comb begin
      dv_ff[0]   = in_valid;
      ds_ff[0]   = in_side;
      dz_ff[0]   = (in_num == 64'd0);
      drem_ff[0] = {1'b0, in_den - in_num};
      dden_ff[0] = in_den;
      dq_ff[0]   = '0;
   end

   for (genvar i = 0; i < DivStages; i++) begin : g_div
      logic [64:0] sh;
      logic        ge;
      assign sh = {drem_ff[i][63:0], 1'b0};
      assign ge = (sh >= {1'b0, dden_ff[i]});
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1] <= 1'b0;
         end else if (advance) begin
            dv_ff[i+1] <= dv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            ds_ff[i+1]   <= ds_ff[i];
            dz_ff[i+1]   <= dz_ff[i];
            dden_ff[i+1] <= dden_ff[i];
            drem_ff[i+1] <= ge ? (sh - {1'b0, dden_ff[i]}) : sh;
            dq_ff[i+1]   <= {dq_ff[i][62:0], ge};
         end
      end
   end

   always_comb begin
      qv_ff[0]    = dv_ff[DivStages];
      qs_ff[0]    = ds_ff[DivStages];
      qz_ff[0]    = dz_ff[DivStages];
      qrad_ff[0]  = dq_ff[DivStages];
      qrem_ff[0]  = '0;
      qroot_ff[0] = '0;
   end

   // Digit-by-digit root: bring down two radicand bits each step.
   for (genvar i = 0; i < SqStages; i++) begin : g_sqrt
      logic [33:0] tr, trial;
      logic        ok;
      assign tr    = {qrem_ff[i][31:0], qrad_ff[i][63:62]};
      assign trial = {qroot_ff[i], 2'b01};
      assign ok    = (tr >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[i+1] <= 1'b0;
         end else if (advance) begin
            qv_ff[i+1] <= qv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            qs_ff[i+1]    <= qs_ff[i];
            qz_ff[i+1]    <= qz_ff[i];
            qrad_ff[i+1]  <= {qrad_ff[i][61:0], 2'b00};
            qrem_ff[i+1]  <= ok ? (tr - trial) : tr;
            qroot_ff[i+1] <= {qroot_ff[i][30:0], ok};
         end
      end
   end

   always_comb begin
      gv_ff[0]   = qv_ff[SqStages];
      gs_ff[0]   = qs_ff[SqStages];
      gz_ff[0]   = qz_ff[SqStages];
      grem_ff[0] = '0;
      // A zero root only shows up for items already flagged or N = 0.
      gden_ff[0] = (qroot_ff[SqStages] == 32'd0) ? 32'd1 : qroot_ff[SqStages];
      gq_ff[0]   = '0;
   end

   // Dividend 2^64 (65 bits, msb first); equals the model's rounding of
   // (2^64 - 1) / s plus one when s divides 2^64.
   for (genvar i = 0; i < GStages; i++) begin : g_recip
      logic [32:0] sh;
      logic        ge;
      assign sh = {grem_ff[i][31:0], (i == 0) ? 1'b1 : 1'b0};
      assign ge = (sh >= {1'b0, gden_ff[i]});
      always_ff @(posedge clock) begin
         if (reset) begin
            gv_ff[i+1] <= 1'b0;
         end else if (advance) begin
            gv_ff[i+1] <= gv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            gs_ff[i+1]   <= gs_ff[i];
            gz_ff[i+1]   <= gz_ff[i];
            gden_ff[i+1] <= gden_ff[i];
            grem_ff[i+1] <= ge ? (sh - {1'b0, gden_ff[i]}) : sh;
            gq_ff[i+1]   <= {gq_ff[i][63:0], ge};
         end
      end
   end

   // With N < D the root is at least 8, so gamma stays below 2^62 and the
   // low 64 quotient bits hold it in full.
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (advance) begin
         fv_ff <= gv_ff[GStages];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fs_ff <= gs_ff[GStages];
         if (gz_ff[GStages]) begin
            fg_ff <= 64'h1_0000_0000;
         end else begin
            fg_ff <= gq_ff[GStages][63:0];
         end
      end
   end

   assign out_valid = fv_ff;
   assign out_side  = fs_ff;
   assign out_gamma = fg_ff;
endmodule

// ===== sv/tofrk_back.sv =====
// ============================================================================
// tofrk_back
// Energies from gamma and mass, per-axis beta by division, momenta, and
// output saturation.
// ============================================================================
module tofrk_back #(
   parameter int unsigned MASS_W = tofrk_pkg::MassWidth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [MASS_W-1:0]        mass,
   input  logic                     in_valid,
   input  tofrk_pkg::side_type      in_side,
   input  logic [63:0]              in_gamma,
   output logic                     out_valid,
   output logic signed [23:0]       mom_x,
   output logic signed [23:0]       mom_y,
   output logic signed [23:0]       mom_z,
   output logic [23:0]              total_energy,
   output logic [23:0]              kinetic_energy,
   output logic [1:0]               status
);
   import tofrk_pkg::*;

   localparam int unsigned Steps = AxisBits;
   localparam int unsigned PartW = 32 + MASS_W;
   localparam int unsigned SumW  = 64 + MASS_W;

   // Stage A: g*M and (g-1)*M as two 32-bit-half partial products each,
   // and the axis denominators.
   logic        av_ff;
   side_type    as_ff;
   logic [PartW-1:0] pel_ff, peh_ff, pkl_ff, pkh_ff;
   logic [36:0] aden_ff;

   logic [63:0] gm1;
   assign gm1 = in_gamma - 64'h1_0000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else if (advance) begin
         av_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         as_ff   <= in_side;
         pel_ff  <= PartW'(in_gamma[31:0]) * PartW'(mass);
         peh_ff  <= PartW'(in_gamma[63:32]) * PartW'(mass);
         pkl_ff  <= PartW'(gm1[31:0]) * PartW'(mass);
         pkh_ff  <= PartW'(gm1[63:32]) * PartW'(mass);
         aden_ff <= 37'(in_side.t) * 37'(Cq);
      end
   end

   // Any product of 2^64 or more saturates; below that the shifted value
   // always fits the 40-bit cap.
   function automatic logic [39:0] cap40(input logic [PartW-1:0] lo,
                                         input logic [PartW-1:0] hi);
      logic [SumW-1:0] s;
      s = {hi, 32'd0} + SumW'(lo);
      return (s[SumW-1:64] != '0) ? ECap : {2'd0, s[63:26]};
   endfunction

   // Axis beta dividers, 24 quotient bits, one per stage.
   logic        bv_ff [Steps+1];
   side_type    bs_ff [Steps+1];
   logic [39:0] be_ff [Steps+1];
   logic [39:0] bk_ff [Steps+1];
   logic [36:0] bden_ff [Steps+1];
   logic [37:0] brem_ff [Steps+1][3];
   logic [23:0] bq_ff   [Steps+1][3];
   logic [2:0]  bsat_ff [Steps+1];

   always_comb begin
      bv_ff[0]   = av_ff;
      bs_ff[0]   = as_ff;
      be_ff[0]   = cap40(pel_ff, peh_ff);
      bk_ff[0]   = cap40(pkl_ff, pkh_ff);
      bden_ff[0] = aden_ff;
      brem_ff[0][0] = {3'd0, as_ff.mag_x, 18'd0};
      brem_ff[0][1] = {3'd0, as_ff.mag_y, 18'd0};
      brem_ff[0][2] = {3'd0, as_ff.mag_z, 18'd0};
      for (int a = 0; a < 3; a++) begin
         bq_ff[0][a]   = '0;
         bsat_ff[0][a] = (brem_ff[0][a] >= {1'b0, aden_ff});
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_axis
      always_ff @(posedge clock) begin
         if (reset) begin
            bv_ff[i+1] <= 1'b0;
         end else if (advance) begin
            bv_ff[i+1] <= bv_ff[i];
         end
      end
      for (genvar a = 0; a < 3; a++) begin : g_lane
         logic [37:0] sh;
         logic        ge;
         assign sh = {brem_ff[i][a][36:0], 1'b0};
         assign ge = (sh >= {1'b0, bden_ff[i]});
         always_ff @(posedge clock) begin
            if (advance) begin
               brem_ff[i+1][a] <= ge ? (sh - {1'b0, bden_ff[i]}) : sh;
               bq_ff[i+1][a]   <= {bq_ff[i][a][22:0], ge};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            bs_ff[i+1]   <= bs_ff[i];
            be_ff[i+1]   <= be_ff[i];
            bk_ff[i+1]   <= bk_ff[i];
            bden_ff[i+1] <= bden_ff[i];
            bsat_ff[i+1] <= bsat_ff[i];
         end
      end
   end

   // Stage M: E*b split into two partial products per axis (40 = 20+20).
   logic        mv_ff;
   side_type    ms_ff;
   logic [39:0] me_ff, mk_ff;
   logic [43:0] plo_ff [3];
   logic [43:0] phi_ff [3];
   logic [23:0] bsel [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         bsel[a] = bsat_ff[Steps][a] ? 24'hFFFFFF : bq_ff[Steps][a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (advance) begin
         mv_ff <= bv_ff[Steps];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ms_ff <= bs_ff[Steps];
         me_ff <= be_ff[Steps];
         mk_ff <= bk_ff[Steps];
         for (int a = 0; a < 3; a++) begin
            plo_ff[a] <= 44'(be_ff[Steps][19:0]) * 44'(bsel[a]);
            phi_ff[a] <= 44'(be_ff[Steps][39:20]) * 44'(bsel[a]);
         end
      end
   end

   // Stage O: combine, shift, saturate, zero on bad status.
   logic [64:0] prod [3];
   logic [28:0] pm [3];
   logic [23:0] mom_in [3];
   logic [39:0] e12, k12;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a] = {phi_ff[a], 20'd0} + 65'(plo_ff[a]);
         pm[a]   = prod[a][64:36];
         if (ms_ff.neg[a]) begin
            mom_in[a] = (pm[a] > 29'h800000) ? 24'h800000 : 24'(25'h1000000 - 25'(pm[a]));
         end else begin
            mom_in[a] = (pm[a] > 29'h7FFFFF) ? 24'h7FFFFF : pm[a][23:0];
         end
         if (ms_ff.status != StatusOk) begin
            mom_in[a] = '0;
         end
      end
      e12 = me_ff >> 12;
      k12 = mk_ff >> 12;
   end

   logic        ov_ff;
   logic [23:0] mx_ff, my_ff, mz_ff, te_ff, ke_ff;
   logic [1:0]  st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (advance) begin
         ov_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff <= mom_in[0];
         my_ff <= mom_in[1];
         mz_ff <= mom_in[2];
         st_ff <= ms_ff.status;
         if (ms_ff.status != StatusOk) begin
            te_ff <= '0;
            ke_ff <= '0;
         end else begin
            te_ff <= (e12[39:24] != 16'd0) ? 24'hFFFFFF : e12[23:0];
            ke_ff <= (k12[39:24] != 16'd0) ? 24'hFFFFFF : k12[23:0];
         end
      end
   end

   assign out_valid      = ov_ff;
   assign mom_x          = mx_ff;
   assign mom_y          = my_ff;
   assign mom_z          = mz_ff;
   assign total_energy   = te_ff;
   assign kinetic_energy = ke_ff;
   assign status         = st_ff;
endmodule

// ===== sv/tof_relativistic_kinematics.sv =====
// ============================================================================
// tof_relativistic_kinematics
// Momentum and energy of one time-of-flight hit for a set particle mass.
// ============================================================================
// Usage: a hit beat on req_ (pos_x/y/z, flight_time) is taken when req_valid
// is high and req_stall low. One result beat leaves on rsp_ per hit, in
// order, taken when rsp_valid is high and rsp_stall low.
// The pipeline takes one hit every cycle while not held. Its stages: 2 front
// stages, 64 ratio-division stages, 32 root stages, 65 reciprocal stages,
// one gamma select stage, then mass product, 24 axis-division stages,
// partial products and output; the bit-per-stage dividers and root are most.
// The whole pipeline holds while rsp_stall is high and a result waits;
// req_stall follows that, so nothing is lost or repeated. Bubbles are not
// removed; they travel with the pipeline like any other beat.
// The mass is written on csr_ (valid/ready, always ready); write it only
// while no hit is in flight. Reset empties the pipeline and loads the
// neutron mass.
// ============================================================================
module tof_relativistic_kinematics #(
   parameter int unsigned MASS_W = tofrk_pkg::MassWidth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [16:0]  req_pos_x,
   input  logic signed [16:0]  req_pos_y,
   input  logic signed [16:0]  req_pos_z,
   input  logic [15:0]         req_flight_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [23:0]  rsp_mom_x,
   output logic signed [23:0]  rsp_mom_y,
   output logic signed [23:0]  rsp_mom_z,
   output logic [23:0]         rsp_total_energy,
   output logic [23:0]         rsp_kinetic_energy,
   output logic [1:0]          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [MASS_W-1:0]   csr_particle_mass
);
   import tofrk_pkg::*;

   logic [MASS_W-1:0] mass_ff;
   logic              advance;
   logic              fv;
   side_type          fs;
   logic [63:0]       fn, fd;
   logic              gv;
   side_type          gs;
   logic [63:0]       gg;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= MASS_W'(MassReset);
      end else if (csr_valid && csr_ready) begin
         mass_ff <= csr_particle_mass;
      end
   end

   tofrk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .pos_z       (req_pos_z),
      .flight_time (req_flight_time),
      .out_valid   (fv),
      .out_side    (fs),
      .out_num     (fn),
      .out_den     (fd)
   );

   tofrk_gamma u_gamma (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fv),
      .in_side   (fs),
      .in_num    (fn),
      .in_den    (fd),
      .out_valid (gv),
      .out_side  (gs),
      .out_gamma (gg)
   );

   tofrk_back #(.MASS_W(MASS_W)) u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .mass           (mass_ff),
      .in_valid       (gv),
      .in_side        (gs),
      .in_gamma       (gg),
      .out_valid      (rsp_valid),
      .mom_x          (rsp_mom_x),
      .mom_y          (rsp_mom_y),
      .mom_z          (rsp_mom_z),
      .total_energy   (rsp_total_energy),
      .kinetic_energy (rsp_kinetic_energy),
      .status         (rsp_status)
   );

   // A bad status always comes with zeroed energies.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StatusOk |-> rsp_total_energy == 24'd0)
      else $error("nonzero energy with bad status");

   // Status never takes the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("illegal status code");

   // Kinetic energy never exceeds total energy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kinetic_energy <= rsp_total_energy)
      else $error("kinetic above total");

   // A held result stays while stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_energy))
      else $error("result changed under stall");
endmodule

// ===== bench/tof_relativistic_kinematics_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for tof_relativistic_kinematics
// Drives hits through the kinematics pipeline under random idling on both
// sides and checks every result beat, field by field and in order. Expected
// results come from a table for known directed rows, else from a bit-accurate
// fixed-point predictor of gamma, momentum and energy. The run also covers several particle masses.
// ----------------------------------------------------------------------------
module tof_relativistic_kinematics_test;
   import tofrk_pkg::*;

   typedef struct packed {
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
      logic [15:0]        t;
   } hit_type;

   typedef struct packed {
      logic signed [23:0] mom_x;
      logic signed [23:0] mom_y;
      logic signed [23:0] mom_z;
      logic [23:0]        total;
      logic [23:0]        kinetic;
      logic [1:0]         status;
   } kin_type;

   typedef struct packed {
      hit_type hit;
      logic    known;
      kin_type kin;
   } row_type;

   localparam int Latency = 250;
   localparam int RandomPerPhase = 225;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [16:0] req_pos_x;
   logic signed [16:0] req_pos_y;
   logic signed [16:0] req_pos_z;
   logic [15:0] req_flight_time;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [23:0] rsp_mom_x;
   logic signed [23:0] rsp_mom_y;
   logic signed [23:0] rsp_mom_z;
   logic [23:0] rsp_total_energy;
   logic [23:0] rsp_kinetic_energy;
   logic [1:0] rsp_status;
   logic csr_valid;
   logic csr_ready;
   logic [23:0] csr_particle_mass;

   logic [23:0] mass_copy;
   kin_type pending_kin[$];
   logic pending_known[$];
   kin_type known_kin[$];
   int errors;
   int hits_sent;
   int results_seen;
   bit calm;

   tof_relativistic_kinematics i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_flight_time(req_flight_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mom_x(rsp_mom_x), .rsp_mom_y(rsp_mom_y), .rsp_mom_z(rsp_mom_z),
      .rsp_total_energy(rsp_total_energy), .rsp_kinetic_energy(rsp_kinetic_energy),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_particle_mass(csr_particle_mass)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [127:0] mass_scaled(logic [127:0] g, logic [23:0] m);
      logic [127:0] prod;
      logic [127:0] e;
      prod = g * m;
      if (prod >= (128'd1 << 64)) return {88'd0, ECap};
      e = prod >> 26;
      return (e > ECap) ? {88'd0, ECap} : e;
   endfunction

   function automatic kin_type kinematics(hit_type h, logic [23:0] m);
      kin_type res;
      logic [17:0] mag[3];
      logic neg[3];
      logic signed [16:0] pos[3];
      logic [127:0] r2, n, d, s2, s, g, e, k, num, den, b, p;
      int i;
      res = '0;
      pos[0] = h.x;
      pos[1] = h.y;
      pos[2] = h.z;
      r2 = '0;
      for (i = 0; i < 3; i++) begin
         neg[i] = pos[i][16];
         mag[i] = neg[i] ? (18'h20000 - {1'b0, pos[i]}) : {1'b0, pos[i]};
         r2 = r2 + mag[i] * mag[i];
      end
      if (h.t == 0) begin
         res.status = StatusZeroTime;
         return res;
      end
      n = r2 << 20;
      d = h.t * h.t * C2q;
      if (n >= d) begin
         res.status = StatusFast;
         return res;
      end
      if (n == 0) begin
         g = 128'd1 << 32;
      end else begin
         s2 = ((d - n) << 64) / d;
         s = root_floor(s2[63:0]);
         g = (128'd1 << 64) / s;
      end
      e = mass_scaled(g, m);
      k = mass_scaled(g - (128'd1 << 32), m);
      for (i = 0; i < 3; i++) begin
         num = mag[i] << 18;
         den = h.t * Cq;
         b = (num >= den) ? ((128'd1 << 24) - 1) : ((num << 24) / den);
         p = (e * b) >> 36;
         if (neg[i]) begin
            if (p > 128'h800000) p = 128'h800000;
            p = 128'h1000000 - p;
         end else if (p > 128'h7FFFFF) begin
            p = 128'h7FFFFF;
         end
         if (i == 0) res.mom_x = p[23:0];
         else if (i == 1) res.mom_y = p[23:0];
         else res.mom_z = p[23:0];
      end
      e = e >> 12;
      k = k >> 12;
      res.total = (e > 128'hFFFFFF) ? 24'hFFFFFF : e[23:0];
      res.kinetic = (k > 128'hFFFFFF) ? 24'hFFFFFF : k[23:0];
      res.status = StatusOk;
      return res;
   endfunction

   // Signed position with the given magnitude; a random sign where both fit.
   function automatic logic signed [16:0] signed_pos(int unsigned mag);
      if (mag > 65536) mag = 65536;
      if (mag == 65536 || $urandom_range(0, 1)) return 17'(-$signed({1'b0, mag[16:0]}));
      return mag[16:0];
   endfunction

   function automatic hit_type random_hit();
      hit_type h;
      int unsigned kind, bound;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         h.t = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 255))
                                        : 16'($urandom_range(1, 65535));
         bound = h.t * 4;
         h.x = signed_pos($urandom_range(0, bound));
         h.y = signed_pos($urandom_range(0, bound));
         h.z = signed_pos($urandom_range(0, bound));
      end else if (kind < 85) begin
         // Nearly all on one axis, close to the speed of light, for large gamma.
         h.t = 16'($urandom_range(1, 65535));
         bound = h.t * 7;
         h.x = signed_pos($urandom_range(bound, bound + h.t / 2));
         h.y = '0;
         h.z = signed_pos($urandom_range(0, 2));
      end else begin
         h.x = 17'($urandom);
         h.y = 17'($urandom);
         h.z = 17'($urandom);
         h.t = $urandom_range(0, 19) == 0 ? 16'd0 : 16'($urandom);
      end
      return h;
   endfunction

   task automatic send_hit(hit_type h, logic known, kin_type kin);
      if (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      pending_known.push_back(known);
      known_kin.push_back(kin);
      req_valid <= 1'b1;
      req_pos_x <= h.x;
      req_pos_y <= h.y;
      req_pos_z <= h.z;
      req_flight_time <= h.t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hits_sent++;
   endtask

   task automatic write_mass(logic [23:0] m);
      req_valid <= 1'b0;
      while (pending_kin.size() != 0 || pending_known.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
      csr_valid <= 1'b1;
      csr_particle_mass <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mass_copy = m;
   endtask

   // Accepted hits: predict now, with the mass in force at acceptance.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (pending_known.pop_front()) begin
            pending_kin.push_back(known_kin.pop_front());
         end else begin
            void'(known_kin.pop_front());
            pending_kin.push_back(kinematics({req_pos_x, req_pos_y, req_pos_z,
                                              req_flight_time}, mass_copy));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
      end
   end

   always @(posedge clock) begin
      kin_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_kin.size() == 0) begin
            $error("result beat with no hit outstanding");
            errors++;
         end else begin
            want = pending_kin.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_mom_x !== want.mom_x) begin
               $error("mom_x: expected %0d, got %0d", want.mom_x, rsp_mom_x);
               errors++;
            end
            if (rsp_mom_y !== want.mom_y) begin
               $error("mom_y: expected %0d, got %0d", want.mom_y, rsp_mom_y);
               errors++;
            end
            if (rsp_mom_z !== want.mom_z) begin
               $error("mom_z: expected %0d, got %0d", want.mom_z, rsp_mom_z);
               errors++;
            end
            if (rsp_total_energy !== want.total) begin
               $error("total_energy: expected %0d, got %0d", want.total,
                      rsp_total_energy);
               errors++;
            end
            if (rsp_kinetic_energy !== want.kinetic) begin
               $error("kinetic_energy: expected %0d, got %0d", want.kinetic,
                      rsp_kinetic_energy);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type rows[14];
      kin_type zero_t, too_fast, at_rest;
      logic [23:0] masses[5];
      int i, j, waited;
      errors = 0;
      hits_sent = 0;
      results_seen = 0;
      calm = 1'b0;
      mass_copy = MassReset;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_flight_time = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_particle_mass = '0;

      zero_t = '0;
      zero_t.status = StatusZeroTime;
      too_fast = '0;
      too_fast.status = StatusFast;
      at_rest = '0;
      at_rest.status = StatusOk;
      at_rest.total = 24'd15033;   // neutron mass / 64
      rows[0]  = '{'{17'sd0, 17'sd0, 17'sd0, 16'd0}, 1'b1, zero_t};
      rows[1]  = '{'{17'sd65535, -17'sd65536, 17'sd65535, 16'd0}, 1'b1, zero_t};
      rows[2]  = '{'{17'sd65535, 17'sd65535, 17'sd65535, 16'd1}, 1'b1, too_fast};
      rows[3]  = '{'{-17'sd65536, 17'sd0, 17'sd0, 16'd1}, 1'b1, too_fast};
      rows[4]  = '{'{17'sd0, 17'sd0, 17'sd0, 16'd65535}, 1'b1, at_rest};
      rows[5]  = '{'{17'sd0, 17'sd0, 17'sd0, 16'd1}, 1'b1, at_rest};
      rows[6]  = '{'{-17'sd65536, -17'sd65536, -17'sd65536, 16'd65535}, 1'b0, '0};
      rows[7]  = '{'{17'sd65535, 17'sd65535, 17'sd65535, 16'd65535}, 1'b0, '0};
      rows[8]  = '{'{17'sd65535, 17'sd0, 17'sd0, 16'd9000}, 1'b0, '0};
      rows[9]  = '{'{17'sd0, -17'sd65536, 17'sd0, 16'd8760}, 1'b0, '0};
      rows[10] = '{'{17'sd7, -17'sd7, 17'sd0, 16'd2}, 1'b0, '0};
      rows[11] = '{'{17'sd1, 17'sd1, 17'sd1, 16'd1}, 1'b0, '0};
      rows[12] = '{'{17'sd1, -17'sd1, 17'sd1, 16'd65535}, 1'b0, '0};
      rows[13] = '{'{17'sd30000, -17'sd20000, 17'sd10000, 16'd40000}, 1'b0, '0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 14; i++) send_hit(rows[i].hit, rows[i].known, rows[i].kin);

      masses[0] = 24'd1;
      masses[1] = 24'hFFFFFF;
      masses[2] = 24'd0;
      masses[3] = 24'($urandom_range(1, 24'hFFFFFF));
      masses[4] = MassReset;
      for (j = 0; j <= 5; j++) begin
         if (j > 0) write_mass(masses[j-1]);
         for (i = 0; i < RandomPerPhase; i++) begin
            calm = (j == 2 && i >= 40 && i < 160);
            send_hit(random_hit(), 1'b0, '0);
         end
         calm = 1'b0;
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_kin.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (Latency) @(posedge clock);
      if (pending_kin.size() != 0) begin
         $error("%0d expected results never arrived", pending_kin.size());
         errors++;
      end
      $display("Sent %0d hits over six mass settings, checked %0d results.",
               hits_sent, results_seen);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
